// File: hdl/gmps_pkg.sv
package gmps_pkg;

  // Grid limits and field widths
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W    = COL_W + 1;
  localparam int RCNT_W   = ROW_W + 1;
  localparam int SIZE_W   = 11;
  localparam int VAL_W    = 16;
  localparam int SUM_W    = 32;

  // Register file
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  typedef enum logic [ADDR_W-3:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_t;

  // Write request into the row chain: shift on every accepted cell, load
  // the new best sum at the cell that sits cols_eff (clamped grid_cols) places from the end
  typedef struct packed {
    logic             shift;
    logic [COL_W-1:0] insert_pos;
    logic [SUM_W-1:0] best;
  } row_wr_t;

endpackage

// File: hdl/gmps_cell.sv
module gmps_cell
  import gmps_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic             load,
  input  logic [SUM_W-1:0] fill,
  input  logic [SUM_W-1:0] prev,
  output logic [SUM_W-1:0] value
);

  // Take the new best sum at the insert point, else pass the neighbor's value on
  always_ff @(posedge clk) begin
    if (shift) begin
      value <= load ? fill : prev;
    end
  end

endmodule

// File: hdl/gmps_chain.sv
module gmps_chain
  import gmps_pkg::*;
(
  input  logic             clk,
  input  row_wr_t          wr,
  output logic [SUM_W-1:0] above
);

  logic [SUM_W-1:0] cell_q [MAX_COLS];

  // Row of cells: a best sum enters at insert_pos and reaches the last cell
  // exactly one grid row later
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    logic [SUM_W-1:0] prev;
    logic             load;

    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = cell_q[k-1];
    end

    assign load = (wr.insert_pos == COL_W'(k));

    gmps_cell u_cell (
      .clk   (clk),
      .shift (wr.shift),
      .load  (load),
      .fill  (wr.best),
      .prev  (prev),
      .value (cell_q[k])
    );
  end

  assign above = cell_q[MAX_COLS-1];

endmodule

// File: hdl/grid_max_path_sum_unit.sv
// Maximum right/down path sum over a grid, one cell per request.
// Input channel: cell_value with in_valid/in_stall, cells in row-major order.
// Output channel: cell_best/is_final with out_valid/out_stall, one result per
// cell; is_final marks the bottom-right cell, whose best sum is the answer.
// Configuration: APB port, grid_rows at 0x0, grid_cols at 0x4; writing either
// restarts the walk at the top-left cell. Write only while the block is idle.
// A result shows in the cycle after acceptance unless an earlier one is stalled.
// Throughput: one cell per cycle while in_stall is low. The best sums of the
// row above travel through a chain of MAX_COLS register cells that shifts
// once per accepted cell, so the value above is always read from the last cell.
// The left sum is registered in left_best and feeds the next cell's add.
// When the receiver stalls, one more result is held in a skid register;
// in_stall rises only once that register is full.
// Reset: the walk restarts, both sizes go to 1 and no result is pending;
// the row chain keeps no reset and is only read after the row above is done.
module grid_max_path_sum_unit
  import gmps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // cell requests
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VAL_W-1:0]  cell_value,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SUM_W-1:0]  cell_best,
  output logic              is_final
);

  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [RCNT_W-1:0] rows_eff;
  logic [CNT_W-1:0]  cols_eff;
  logic [ROW_W-1:0]  row_idx;
  logic [COL_W-1:0]  col_idx;
  logic [SUM_W-1:0]  left_best;
  logic [SUM_W-1:0]  above;
  logic [SUM_W-1:0]  top_sum;
  logic [SUM_W-1:0]  pick;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  best_new;
  logic              last_col;
  logic              last_row;
  logic              final_new;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic              in_accept;
  logic              out_take;
  logic              skid_valid;
  logic [SUM_W-1:0]  skid_best;
  logic              skid_final;
  row_wr_t           row_wr;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SIZE_W'(1);
      grid_cols <= SIZE_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_ROWS: grid_rows <= pwdata[SIZE_W-1:0];
        REG_GRID_COLS: grid_cols <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_ROWS: prdata = DATA_W'(grid_rows);
      REG_GRID_COLS: prdata = DATA_W'(grid_cols);
      default:       prdata = '0;
    endcase
  end

  // Clamp sizes into range
  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(grid_cols);
    end
  end

  // Best sum for the incoming cell: max of above and left, add, saturate
  assign top_sum   = (row_idx == '0) ? '0 : above;
  assign pick      = (top_sum > left_best) ? top_sum : left_best;
  assign sum_wide  = {1'b0, pick} + (SUM_W+1)'(cell_value);
  assign best_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign last_col  = ((CNT_W'(col_idx) + CNT_W'(1)) == cols_eff);
  assign last_row  = ((RCNT_W'(row_idx) + RCNT_W'(1)) == rows_eff);
  assign final_new = last_col && last_row;

  // Row chain write request
  assign in_stall          = skid_valid;
  assign in_accept         = in_valid && !skid_valid;
  assign row_wr.shift      = in_accept;
  assign row_wr.insert_pos = COL_W'(CNT_W'(MAX_COLS) - cols_eff);
  assign row_wr.best       = best_new;

  gmps_chain u_chain (
    .clk   (clk),
    .wr    (row_wr),
    .above (above)
  );

  // Advance the walk; a configuration write restarts it
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_idx   <= '0;
      col_idx   <= '0;
      left_best <= '0;
    end else if (in_accept) begin
      if (final_new) begin
        row_idx   <= '0;
        col_idx   <= '0;
        left_best <= '0;
      end else if (last_col) begin
        row_idx   <= row_idx + ROW_W'(1);
        col_idx   <= '0;
        left_best <= '0;
      end else begin
        col_idx   <= col_idx + COL_W'(1);
        left_best <= best_new;
      end
    end
  end

  // Output register with one skid entry behind it
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Hold payloads; move the skid entry forward when the output drains
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        cell_best <= skid_best;
        is_final  <= skid_final;
      end
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        cell_best <= best_new;
        is_final  <= final_new;
      end else begin
        skid_best  <= best_new;
        skid_final <= final_new;
      end
    end
  end

endmodule

// File: hdl/gmps_checker.sv
module gmps_checker
  import gmps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SUM_W-1:0]  cell_best,
  input logic              is_final
);

  // A stalled result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_best) && $stable(is_final))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result pending after reset");

  // Requests are held back only while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("request stalled with no result waiting");

  // The skid entry fills only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
    else $error("request stall without a stalled result");

endmodule

bind grid_max_path_sum_unit gmps_checker u_gmps_checker (.*);
